// File: hw/rtl/assert_macros.svh
// Assertion shorthands shared by the RTL files that check themselves.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: hw/rtl/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
// No dependencies; imported by every module of the block but mm_ram.
package mm_pkg;

  localparam int MAX_DIM = 32;
  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int IDX_W   = 5;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 48;
  localparam int LEN_W   = 6;

  localparam logic [LEN_W-1:0] INNER_LEN_RST = 6'd32;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ACC_W - 2 * IDX_W;

  typedef enum logic [1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Sequencer to multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic term_vld;
  } mac_ctl_t;

  // Sequencer to output register.
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } out_ctl_t;

endpackage

// File: hw/rtl/mm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mm_mac.sv
// Shared multiply-accumulate unit: registered 16x16 signed product, 48-bit sum.
// Depends on mm_pkg.
module mm_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  mm_pkg::mac_ctl_t               ctl,
  input  logic signed [mm_pkg::ELEM_W-1:0] a_data,
  input  logic signed [mm_pkg::ELEM_W-1:0] b_data,
  output logic                           busy,
  output logic signed [mm_pkg::ACC_W-1:0]  acc
);
  import mm_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.term_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = prod_vld;

endmodule

// File: hw/rtl/mm_ctrl.sv
// Sequencer: takes requests, writes the element stores, walks the inner loop.
// Depends on mm_pkg.
module mm_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mm_pkg::req_type_t         req_type,
  input  logic [mm_pkg::IDX_W-1:0]  row_index,
  input  logic [mm_pkg::IDX_W-1:0]  col_index,
  input  logic [mm_pkg::LEN_W-1:0]  inner_len,
  input  logic                      mac_busy,
  input  logic                      out_free,
  output logic                      a_we,
  output logic                      b_we,
  output logic [mm_pkg::ADDR_W-1:0] waddr,
  output logic [mm_pkg::ADDR_W-1:0] a_raddr,
  output logic [mm_pkg::ADDR_W-1:0] b_raddr,
  output mm_pkg::mac_ctl_t          mac_ctl,
  output mm_pkg::out_ctl_t          out_ctl
);
  import mm_pkg::*;

  state_t           state, state_next;
  logic [DIM_W-1:0] k, last_k;
  logic [IDX_W-1:0] row_q, col_q;
  logic             rd_vld;

  logic             accept, compute, in_range, pipe_empty, issue;
  logic [CNT_W-1:0] n_terms;

  assign accept     = in_valid && in_ready;
  assign compute    = accept && (req_type == REQ_COMPUTE);
  assign in_range   = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign n_terms    = (32'(inner_len) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(inner_len);
  assign pipe_empty = !rd_vld && !mac_busy;

  // Element writes go straight to the stores.
  assign waddr = ADDR_W'(row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index);
  assign a_we  = accept && in_range && (req_type == REQ_WRITE_A);
  assign b_we  = accept && in_range && (req_type == REQ_WRITE_B);

  // Row of A is contiguous, column of B strides by MAX_DIM.
  assign a_raddr = ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k);
  assign b_raddr = ADDR_W'(k) * ADDR_W'(MAX_DIM) + ADDR_W'(col_q);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (compute) begin
          state_next = (in_range && n_terms != '0) ? ST_ISSUE : ST_DRAIN;
        end
      end
      ST_ISSUE: begin
        if (k == last_k) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    issue            = 1'b0;
    out_ctl.load     = 1'b0;
    case (state)
      ST_IDLE:  in_ready     = 1'b1;
      ST_ISSUE: issue        = 1'b1;
      ST_DRAIN: out_ctl.load = pipe_empty && out_free;
      default: ;
    endcase
    mac_ctl.clear    = compute;
    mac_ctl.term_vld = rd_vld;
    out_ctl.row      = row_q;
    out_ctl.col      = col_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (compute) begin
      row_q  <= row_index;
      col_q  <= col_index;
      k      <= '0;
      last_k <= DIM_W'(n_terms - CNT_W'(1));
    end else if (issue) begin
      k <= k + DIM_W'(1);
    end
  end

endmodule

// File: hw/rtl/matrix_multiply.sv
// Matrix multiply C = A x B, one result element per compute request.
// A compute sums terms = min(inner_len, MAX_DIM) products; with zero terms it goes
// straight to the drain phase and returns a zero sum.
// Paced by one shared multiply-accumulate unit fed from two RAM read ports, one term a cycle.
// Throughput: one write per cycle while idle; a compute blocks input until its result loads.
// Reset (rst, synchronous): idle, output empty, inner_len = 32; stores keep data.
`include "assert_macros.svh"

module matrix_multiply (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: inner_len
  input  logic                           cfg_wen,
  input  logic [mm_pkg::LEN_W-1:0]       cfg_wdata,
  // Request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] row_index, [9:5] col_index, [25:10] element_value, [31:26] zero
  input  logic [mm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [mm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] out_row, [9:5] out_col, [57:10] product_sum, [63:58] zero
  output logic [mm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mm_pkg::*;

  logic [LEN_W-1:0]         inner_len;
  logic [IDX_W-1:0]         row_index, col_index;
  logic signed [ELEM_W-1:0] element_value;
  req_type_t                req_type;

  logic                     a_we, b_we;
  logic [ADDR_W-1:0]        waddr, a_raddr, b_raddr;
  logic signed [ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_busy, out_free;
  mac_ctl_t                 mac_ctl;
  out_ctl_t                 out_ctl;
  logic                     compute_accept;

  // Unpack the request.
  assign row_index     = s_axis_tdata[IDX_W-1:0];
  assign col_index     = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign element_value = s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
  assign req_type      = req_type_t'(s_axis_tuser);

  // Shared dimension register; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len <= INNER_LEN_RST;
    end else if (cfg_wen) begin
      inner_len <= cfg_wdata;
    end
  end

  mm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .req_type  (req_type),
    .row_index (row_index),
    .col_index (col_index),
    .inner_len (inner_len),
    .mac_busy  (mac_busy),
    .out_free  (out_free),
    .a_we      (a_we),
    .b_we      (b_we),
    .waddr     (waddr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .mac_ctl   (mac_ctl),
    .out_ctl   (out_ctl)
  );

  // Element stores, row-major, MAX_DIM x MAX_DIM each.
  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .busy   (mac_busy),
    .acc    (acc)
  );

  // Output register: hold the result until the sink takes it.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ctl.load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      m_axis_tdata <= {OUT_PAD_W'(0), acc, out_ctl.col, out_ctl.row};
    end
  end

  assign compute_accept = s_axis_tvalid && s_axis_tready && (req_type == REQ_COMPUTE);

  // No new request while the multiply-accumulate pipeline still holds terms.
  `ASSERT_NEVER(a_ready_while_busy, s_axis_tready && mac_busy, "request taken while MAC busy")
  // Never overwrite a result the sink has not taken.
  `ASSERT_NEVER(a_out_overwrite, out_ctl.load && m_axis_tvalid && !m_axis_tready, "result lost")
  // A compute request blocks the input in the following cycle.
  `ASSERT_CLK(a_compute_blocks, compute_accept |=> !s_axis_tready, "input open after compute")
  // A result is never loaded while the multiply-accumulate unit is busy.
  `ASSERT_NEVER(a_load_needs_idle_mac, out_ctl.load && mac_busy, "result loaded mid-sum")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for matrix_multiply: loads elements of A and B and requests
// dot products, checking each result against a local predictor or a directed sum.
// Depends on mm_pkg and matrix_multiply from the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mm_pkg::*;

  // The request code the block must ignore; the package names only the live ones.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 160;
  localparam int IDLE_PERCENT    = 17;
  // Let the last write settle before reconfiguring.
  localparam int SETTLE_CYCLES   = 4;
  // Drain past the longest compute, of MAX_DIM terms, at the end.
  localparam int TAIL_CYCLES     = 2 * MAX_DIM + 8;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int RX_STEADY_FROM  = 4000;
  localparam int RX_STEADY_TO    = 7000;
  localparam int WATCHDOG_LIMIT  = 3000;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] sum;
  } result_t;

  // One row of the directed table. A row with typed set carries its own
  // expected sum; every other compute row goes through the predictor.
  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
    logic              typed;
    logic [ACC_W-1:0]  sum;
  } stim_row_t;

  localparam int DIRECTED_N = 21;

  // Run with inner_len = 1, so each product reads A[row][0] and B[0][col].
  localparam stim_row_t DIRECTED_REQS [DIRECTED_N] = '{
    '{REQ_WRITE_A, 5'd0,  5'd0,  16'h8000, 1'b0, 48'd0},
    '{REQ_WRITE_B, 5'd0,  5'd0,  16'h8000, 1'b0, 48'd0},
    '{REQ_COMPUTE, 5'd0,  5'd0,  16'h0000, 1'b1, 48'sd1073741824},
    '{REQ_WRITE_A, 5'd31, 5'd0,  16'h7FFF, 1'b0, 48'd0},
    '{REQ_WRITE_B, 5'd0,  5'd31, 16'h8000, 1'b0, 48'd0},
    '{REQ_COMPUTE, 5'd31, 5'd31, 16'hFFFF, 1'b1, -48'sd1073709056},
    '{REQ_COMPUTE, 5'd0,  5'd31, 16'h0000, 1'b1, 48'sd1073741824},
    '{REQ_COMPUTE, 5'd31, 5'd0,  16'h0000, 1'b1, -48'sd1073709056},
    '{REQ_UNUSED,  5'd0,  5'd0,  16'h1234, 1'b0, 48'd0},
    '{REQ_COMPUTE, 5'd0,  5'd0,  16'h0000, 1'b1, 48'sd1073741824},
    '{REQ_WRITE_A, 5'd0,  5'd0,  16'h7FFF, 1'b0, 48'd0},
    '{REQ_WRITE_B, 5'd0,  5'd0,  16'h7FFF, 1'b0, 48'd0},
    '{REQ_COMPUTE, 5'd0,  5'd0,  16'h0000, 1'b1, 48'sd1073676289},
    '{REQ_WRITE_A, 5'd5,  5'd0,  16'h0000, 1'b0, 48'd0},
    '{REQ_COMPUTE, 5'd5,  5'd0,  16'h0000, 1'b1, 48'd0},
    '{REQ_WRITE_A, 5'd10, 5'd0,  16'h0100, 1'b0, 48'd0},
    '{REQ_WRITE_B, 5'd0,  5'd10, 16'h0100, 1'b0, 48'd0},
    '{REQ_COMPUTE, 5'd10, 5'd10, 16'h0000, 1'b1, 48'sd65536},
    '{REQ_WRITE_A, 5'd21, 5'd0,  16'hFFFF, 1'b0, 48'd0},
    '{REQ_UNUSED,  5'd31, 5'd31, 16'hFFFF, 1'b0, 48'd0},
    '{REQ_COMPUTE, 5'd31, 5'd31, 16'h0000, 1'b1, -48'sd1073709056}
  };

  // Inner length per random phase: legal extremes, zero, and values past MAX_DIM.
  localparam int PHASE_N = 11;
  localparam logic [LEN_W-1:0] PHASE_LENS [PHASE_N] = '{
    6'd2, 6'd1, 6'd32, 6'd0, 6'd5, 6'd63, 6'd3, 6'd33, 6'd8, 6'd16, 6'd4
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [LEN_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [4:0] row, [9:5] col, [25:10] value
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;  // [1:0] req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [4:0] row, [9:5] col, [57:10] sum

  // Predictor state: its own copy of both stores, which entries hold data,
  // and the inner length last written.
  logic signed [ELEM_W-1:0] mat_a [MAX_DIM][MAX_DIM];
  logic signed [ELEM_W-1:0] mat_b [MAX_DIM][MAX_DIM];
  bit                       a_written [MAX_DIM][MAX_DIM];
  bit                       b_written [MAX_DIM][MAX_DIM];
  logic [LEN_W-1:0]         len_setting = INNER_LEN_RST;

  result_t pending_results [$];
  int      error_count = 0;
  int      issued_count = 0;
  bit      sender_steady = 1'b0;
  logic    hold_req = 1'b0;

  matrix_multiply DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact Q32.16 dot product of A row and B column over the active terms.
  // Inner lengths past MAX_DIM saturate; zero sums nothing.
  function automatic logic [ACC_W-1:0] predict_dot(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    logic signed [ACC_W-1:0] acc;
    int terms;
    acc = '0;
    terms = (len_setting > MAX_DIM) ? MAX_DIM : int'(len_setting);
    if (row >= MAX_DIM || col >= MAX_DIM)
      return '0;
    for (int k = 0; k < terms; k++)
      acc += mat_a[row][k] * mat_b[k][col];
    return acc;
  endfunction

  function automatic int active_terms();
    return (len_setting > MAX_DIM) ? MAX_DIM : int'(len_setting);
  endfunction

  // True when every entry the product would read has been written.
  function automatic bit pair_ready(input int row, input int col);
    for (int k = 0; k < active_terms(); k++)
      if (!a_written[row][k] || !b_written[k][col])
        return 1'b0;
    return 1'b1;
  endfunction

  // Mostly random bit patterns, with the Q8.8 corner values mixed in.
  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0100;
      4: return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Drop valid and hold until every outstanding result is back, then let the
  // last write settle.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write inner_len; only called with the block idle.
  task automatic set_inner_len(input logic [LEN_W-1:0] len);
    cfg_wen   <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    len_setting = len;
  endtask

  // Offer one request and hold it until accepted, then fold it into the
  // predictor. Valid stays high on return so back-to-back requests need no
  // second assignment in the same step.
  task automatic send_request(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col,
                              input logic [ELEM_W-1:0] value,
                              input logic typed, input logic [ACC_W-1:0] typed_sum);
    result_t res;
    if (!sender_steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, value, col, row};
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);

    // Accepted at this edge.
    case (kind)
      REQ_WRITE_A: begin
        if (row < MAX_DIM && col < MAX_DIM) begin
          mat_a[row][col] = value;
          a_written[row][col] = 1'b1;
        end
      end
      REQ_WRITE_B: begin
        if (row < MAX_DIM && col < MAX_DIM) begin
          mat_b[row][col] = value;
          b_written[row][col] = 1'b1;
        end
      end
      REQ_COMPUTE: begin
        res.row = row;
        res.col = col;
        res.sum = typed ? typed_sum : predict_dot(row, col);
        pending_results.push_back(res);
      end
      default: ;
    endcase
    if (kind != REQ_UNUSED)
      issued_count++;
  endtask

  // One random phase. Most traffic is well-formed: load a row of A and a
  // column of B, then ask for products whose operands are all written. The
  // rest is ignored codes, stray writes and load runs cut short.
  task automatic run_phase(input int target);
    int  pick;
    int  row;
    int  col;
    int  loads;
    int  extra;
    int  tries;
    bit  cut_short;
    while (issued_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_request(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom),
                     1'b0, '0);
      end else if (pick < 16) begin
        send_request($urandom_range(0, 1) ? REQ_WRITE_B : REQ_WRITE_A, IDX_W'($urandom),
                     IDX_W'($urandom), rand_element(), 1'b0, '0);
      end else begin
        row = $urandom_range(0, MAX_DIM - 1);
        col = $urandom_range(0, MAX_DIM - 1);
        cut_short = ($urandom_range(0, 9) == 0);
        loads = cut_short ? $urandom_range(0, active_terms()) : active_terms();
        // Reuse entries already loaded about half the time.
        for (int k = 0; k < loads; k++) begin
          if (!a_written[row][k] || $urandom_range(0, 1))
            send_request(REQ_WRITE_A, IDX_W'(row), IDX_W'(k), rand_element(), 1'b0, '0);
          if (!b_written[k][col] || $urandom_range(0, 1))
            send_request(REQ_WRITE_B, IDX_W'(k), IDX_W'(col), rand_element(), 1'b0, '0);
        end
        if (!cut_short) begin
          send_request(REQ_COMPUTE, IDX_W'(row), IDX_W'(col), ELEM_W'($urandom),
                       1'b0, '0);
          extra = $urandom_range(0, 2);
          for (int n = 0; n < extra; n++) begin
            tries = 0;
            do begin
              row = $urandom_range(0, MAX_DIM - 1);
              col = $urandom_range(0, MAX_DIM - 1);
              tries++;
            end while (!pair_ready(row, col) && tries < 8);
            if (pair_ready(row, col))
              send_request(REQ_COMPUTE, IDX_W'(row), IDX_W'(col), ELEM_W'($urandom),
                           1'b0, '0);
          end
        end
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request from the stimulus,
  // and a window of steady readiness, all timed in its own cycle count.
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_cycle >= RX_STEADY_FROM && rx_cycle < RX_STEADY_TO) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Compare each accepted result with the oldest one predicted.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[4:0] !== want.row)
          report_mismatch("out_row", m_axis_tdata[4:0], want.row);
        if (m_axis_tdata[9:5] !== want.col)
          report_mismatch("out_col", m_axis_tdata[9:5], want.col);
        if (m_axis_tdata[57:10] !== want.sum)
          report_mismatch("product_sum", m_axis_tdata[57:10], want.sum);
      end
    end
  end

  // Watchdog: end the run if no request or result moves for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: corner values with one term per product.
    set_inner_len(6'd1);
    for (int i = 0; i < DIRECTED_N; i++)
      send_request(DIRECTED_REQS[i].kind, DIRECTED_REQS[i].row, DIRECTED_REQS[i].col,
                   DIRECTED_REQS[i].value, DIRECTED_REQS[i].typed, DIRECTED_REQS[i].sum);

    for (int p = 0; p < PHASE_N; p++) begin
      wait_results_drained();
      set_inner_len(PHASE_LENS[p]);
      // Long products here, so a held-off receiver backs up into the input.
      if (p == 2)
        hold_req <= 1'b1;
      sender_steady = (p == 5);
      if (p == 4) begin
        run_phase(issued_count + ITEMS_PER_PHASE / 2);
        wait_results_drained();
      end
      run_phase(issued_count + ITEMS_PER_PHASE);
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
